// ===== sv/pfd_pkg.sv =====
package pfd_pkg;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_DERIV_CUTOFF = 3'd3;
   localparam logic [2:0] CSR_WINDUP_LIMIT = 3'd4;

   // arithmetic constants
   localparam int ProdW = 68;   // 34 x 34 signed product
   localparam int SumW  = 50;   // P + I + D before saturation
   localparam int NumW  = 64;   // divider dividend / quotient
   localparam int DenW  = 48;   // divider divisor
   localparam logic [DenW-1:0] UsPerS  = 48'd1000000;
   localparam logic [DenW-1:0] RcScale = 48'd10430378350;   // 2^16 * 1e6 / (2 pi)
   localparam logic [31:0]     RecipUs = 32'd2251799813;    // floor(2^51 / 1e6)

   typedef enum logic [4:0] {
      OP_NONE,
      OP_MUL_P,
      OP_MUL_EDT,
      OP_MUL_I,
      OP_MUL_RAW,
      OP_MUL_N,
      OP_MUL_F,
      OP_MUL_D,
      OP_MUL_REC,
      OP_MUL_QC,
      OP_ADD_TERM,
      OP_MAG_I,
      OP_DIV_RAW,
      OP_DIV_A,
      OP_ACC,
      OP_RAW,
      OP_ALPHA,
      OP_FILT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic div_done;
   } sts_type;

endpackage

// ===== sv/pfd_div.sv =====
module pfd_div
   import pfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumW-1:0]     num,
   input  logic [DenW-1:0]     den,
   output logic                done,
   output logic [NumW-1:0]     quo
);

   logic [NumW-1:0] num_ff, num_in;
   logic [DenW-1:0] den_ff;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [5:0]      cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DenW:0]   rem_sh;
   logic            ge;

   // one restoring step: shift in a dividend bit, subtract when it fits
   always_comb begin
      rem_sh = {rem_ff, num_ff[NumW-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DenW'(rem_sh - {1'b0, den_ff}) : rem_sh[DenW-1:0];
      num_in = {num_ff[NumW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

// ===== sv/pfd_datapath.sv =====
module pfd_datapath
   import pfd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_func,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_sample,
   input  logic [15:0]        req_delta_us,
   output logic signed [31:0] rsp_drive
);

   localparam int SatW = (DATA_WIDTH < SumW) ? DATA_WIDTH : SumW;
   localparam logic signed [SumW-1:0] SatHi = SumW'((64'sd1 <<< (SatW - 1)) - 64'sd1);
   localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);

   // configuration
   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [30:0]        cutoff_ff, limit_ff;

   // item and working values
   logic               func_ff;
   logic [15:0]        dt_ff;
   logic signed [31:0] smp_ff, err_ff, raw_ff, filt_ff;
   logic signed [32:0] dsm_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [SumW-1:0]  sum_ff;
   logic [16:0]        alpha_ff;
   logic               neg_ff;
   logic [46:0]        mag_ff;
   logic [27:0]        qest_ff;
   logic signed [31:0] drive_ff;

   // controller state kept across items
   logic signed [31:0] integ_ff, last_sample_ff, last_deriv_ff;

   logic signed [32:0] diff_in;
   logic signed [31:0] err_in;
   logic signed [33:0] mul_a, mul_b;
   logic               prod_neg;
   logic [ProdW-1:0]   prod_mag;
   logic               div_start;
   logic [NumW-1:0]    div_num;
   logic [DenW-1:0]    div_den;
   logic               div_done;
   logic [NumW-1:0]    div_quo;
   logic [47:0]        rem_i;
   logic [27:0]        quo_i;
   logic signed [33:0] q34, acc_sum, lim34, acc_in;
   logic signed [31:0] raw_in;
   logic signed [33:0] filt_sum;
   logic signed [SumW-1:0] sat_sum;

   // saturate setpoint minus measurement
   always_comb begin
      diff_in = 33'(req_target) - 33'(req_sample);
      if (diff_in > 33'sh0_7FFF_FFFF)
         err_in = 32'sh7FFF_FFFF;
      else if (diff_in < -33'sh0_8000_0000)
         err_in = -32'sh8000_0000;
      else
         err_in = diff_in[31:0];
   end

   // select multiplier operands
   always_comb begin
      case (cmd.op)
         OP_MUL_P: begin
            mul_a = 34'(kp_ff);
            mul_b = 34'(err_ff);
         end
         OP_MUL_EDT: begin
            mul_a = 34'(err_ff);
            mul_b = 34'($signed({1'b0, dt_ff}));
         end
         OP_MUL_REC: begin
            mul_a = 34'({1'b0, mag_ff[46:15]});
            mul_b = 34'({1'b0, RecipUs});
         end
         OP_MUL_QC: begin
            mul_a = 34'({1'b0, prod_ff[63:36]});
            mul_b = 34'($signed({1'b0, UsPerS}));
         end
         OP_MUL_I: begin
            mul_a = 34'(ki_ff);
            mul_b = 34'(integ_ff);
         end
         OP_MUL_RAW: begin
            mul_a = 34'(dsm_ff);
            mul_b = 34'($signed({1'b0, UsPerS}));
         end
         OP_MUL_N: begin
            mul_a = 34'($signed({1'b0, dt_ff}));
            mul_b = 34'($signed({1'b0, cutoff_ff}));
         end
         OP_MUL_F: begin
            mul_a = 34'($signed({1'b0, alpha_ff}));
            mul_b = 34'(33'(raw_ff) - 33'(last_deriv_ff));
         end
         OP_MUL_D: begin
            mul_a = 34'(kd_ff);
            mul_b = 34'(filt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider operands: magnitude of the last product, sign kept aside
   always_comb begin
      prod_neg  = prod_ff[ProdW-1];
      prod_mag  = prod_neg ? ProdW'(-prod_ff) : ProdW'(prod_ff);
      div_start = 1'b0;
      div_num   = prod_mag[NumW-1:0];
      div_den   = UsPerS;
      case (cmd.op)
         OP_DIV_RAW: begin
            div_start = 1'b1;
            div_den   = DenW'(dt_ff);
         end
         OP_DIV_A: begin
            div_start = 1'b1;
            div_num   = {prod_ff[46:0], 16'd0, 1'b0} >> 1;
            div_den   = DenW'(prod_ff[46:0]) + RcScale;
         end
         default: begin
         end
      endcase
   end

   pfd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // integral update with clamp; the reciprocal estimate is at most one low
   always_comb begin
      rem_i   = {1'b0, mag_ff} - prod_ff[47:0];
      quo_i   = qest_ff + 28'(rem_i >= UsPerS);
      q34     = $signed({6'd0, quo_i});
      acc_sum = 34'(integ_ff) + (neg_ff ? -q34 : q34);
      lim34   = $signed({3'b000, limit_ff});
      if (acc_sum > lim34)
         acc_in = lim34;
      else if (acc_sum < -lim34)
         acc_in = -lim34;
      else
         acc_in = acc_sum;
   end

   // signed raw derivative, saturated to 32 bits
   always_comb begin
      if (!neg_ff && div_quo > NumW'(32'h7FFF_FFFF))
         raw_in = 32'sh7FFF_FFFF;
      else if (neg_ff && div_quo > NumW'(32'h8000_0000))
         raw_in = -32'sh8000_0000;
      else if (neg_ff)
         raw_in = 32'(-div_quo[31:0]);
      else
         raw_in = $signed(div_quo[31:0]);
   end

   always_comb begin
      filt_sum = 34'(last_deriv_ff) + 34'(prod_ff >>> 16);
      if (sum_ff > SatHi)
         sat_sum = SatHi;
      else if (sum_ff < SatLo)
         sat_sum = SatLo;
      else
         sat_sum = sum_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         cutoff_ff <= 31'd1310720;
         limit_ff  <= 31'd6553600;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:    kp_ff     <= $signed(csr_wdata);
            CSR_INTEG_GAIN:   ki_ff     <= $signed(csr_wdata);
            CSR_DERIV_GAIN:   kd_ff     <= $signed(csr_wdata);
            CSR_DERIV_CUTOFF: cutoff_ff <= csr_wdata[30:0];
            CSR_WINDUP_LIMIT: limit_ff  <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // state that persists between items
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff       <= '0;
         last_sample_ff <= '0;
         last_deriv_ff  <= '0;
      end else if (cmd.op == OP_ACC) begin
         integ_ff <= acc_in[31:0];
      end else if (cmd.op == OP_FINISH) begin
         if (func_ff) begin
            integ_ff       <= '0;
            last_sample_ff <= '0;
            last_deriv_ff  <= '0;
         end else if (dt_ff != 16'd0) begin
            last_sample_ff <= smp_ff;
            last_deriv_ff  <= filt_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dt_ff   <= req_delta_us;
         smp_ff  <= req_sample;
         err_ff  <= err_in;
         dsm_ff  <= 33'(last_sample_ff) - 33'(req_sample);
         sum_ff  <= '0;
      end
      case (cmd.op)
         OP_MUL_P, OP_MUL_EDT, OP_MUL_I, OP_MUL_RAW, OP_MUL_N, OP_MUL_F, OP_MUL_D,
         OP_MUL_REC: begin
            prod_ff <= mul_a * mul_b;
         end
         OP_MUL_QC: begin
            prod_ff <= mul_a * mul_b;
            qest_ff <= prod_ff[63:36];
         end
         OP_ADD_TERM: sum_ff <= sum_ff + SumW'(prod_ff >>> 16);
         OP_MAG_I: begin
            neg_ff <= prod_neg;
            mag_ff <= prod_mag[46:0];
         end
         OP_DIV_RAW:  neg_ff   <= prod_neg;
         OP_RAW:      raw_ff   <= raw_in;
         OP_ALPHA:    alpha_ff <= div_quo[16:0];
         OP_FILT:     filt_ff  <= filt_sum[31:0];
         OP_FINISH: begin
            if (func_ff || dt_ff == 16'd0)
               drive_ff <= '0;
            else
               drive_ff <= sat_sum[31:0];
         end
         default: begin
         end
      endcase
   end

   assign sts.skip     = func_ff || (dt_ff == 16'd0);
   assign sts.div_done = div_done;
   assign rsp_drive    = drive_ff;

endmodule

// ===== sv/pfd_ctrl.sv =====
module pfd_ctrl
   import pfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK,
      S_MUL_P, S_ADD_P,
      S_MUL_EDT, S_MAG_I, S_MUL_REC, S_MUL_QC, S_ACC, S_MUL_I, S_ADD_I,
      S_MUL_RAW, S_DIV_RAW, S_WAIT_RAW, S_RAW,
      S_MUL_N, S_DIV_A, S_WAIT_A, S_ALPHA,
      S_MUL_F, S_FILT, S_MUL_D, S_ADD_D,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   op_type    op;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // command for the datapath from the current state
   always_comb begin
      case (state_ff)
         S_MUL_P:   op = OP_MUL_P;
         S_ADD_P:   op = OP_ADD_TERM;
         S_MUL_EDT: op = OP_MUL_EDT;
         S_MAG_I:   op = OP_MAG_I;
         S_MUL_REC: op = OP_MUL_REC;
         S_MUL_QC:  op = OP_MUL_QC;
         S_ACC:     op = OP_ACC;
         S_MUL_I:   op = OP_MUL_I;
         S_ADD_I:   op = OP_ADD_TERM;
         S_MUL_RAW: op = OP_MUL_RAW;
         S_DIV_RAW: op = OP_DIV_RAW;
         S_RAW:     op = OP_RAW;
         S_MUL_N:   op = OP_MUL_N;
         S_DIV_A:   op = OP_DIV_A;
         S_ALPHA:   op = OP_ALPHA;
         S_MUL_F:   op = OP_MUL_F;
         S_FILT:    op = OP_FILT;
         S_MUL_D:   op = OP_MUL_D;
         S_ADD_D:   op = OP_ADD_TERM;
         S_FINISH:  op = out_free ? OP_FINISH : OP_NONE;
         default:   op = OP_NONE;
      endcase
   end

   assign cmd.op   = op;
   assign cmd.load = (state_ff == S_IDLE) && req_valid;

   // sequence the step
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_CHECK;
         S_CHECK:    state_in = sts.skip ? S_FINISH : S_MUL_P;
         S_MUL_P:    state_in = S_ADD_P;
         S_ADD_P:    state_in = S_MUL_EDT;
         S_MUL_EDT:  state_in = S_MAG_I;
         S_MAG_I:    state_in = S_MUL_REC;
         S_MUL_REC:  state_in = S_MUL_QC;
         S_MUL_QC:   state_in = S_ACC;
         S_ACC:      state_in = S_MUL_I;
         S_MUL_I:    state_in = S_ADD_I;
         S_ADD_I:    state_in = S_MUL_RAW;
         S_MUL_RAW:  state_in = S_DIV_RAW;
         S_DIV_RAW:  state_in = S_WAIT_RAW;
         S_WAIT_RAW: if (sts.div_done) state_in = S_RAW;
         S_RAW:      state_in = S_MUL_N;
         S_MUL_N:    state_in = S_DIV_A;
         S_DIV_A:    state_in = S_WAIT_A;
         S_WAIT_A:   if (sts.div_done) state_in = S_ALPHA;
         S_ALPHA:    state_in = S_MUL_F;
         S_MUL_F:    state_in = S_FILT;
         S_FILT:     state_in = S_MUL_D;
         S_MUL_D:    state_in = S_ADD_D;
         S_ADD_D:    state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/pid_filtered_derivative_step_unit.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_func, req_target, req_sample, req_delta_us
// rsp       out        rsp_valid/rsp_stall  rsp_drive
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// A control step runs two divisions on the shared one-bit-per-cycle divider
// plus the multiply and update steps around them.
// A clear beat or a beat with zero elapsed time skips the arithmetic and goes straight to finish.
// One item is in work at a time; the next is taken while a result still waits.
// Synchronous active-high reset returns gains to zero and clears all history.
// A stalled result holds the finish of the following item until it is taken.
module pid_filtered_derivative_step_unit
   import pfd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_sample,
   input  logic [15:0]        req_delta_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   pfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfd_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_func     (req_func),
      .req_target   (req_target),
      .req_sample   (req_sample),
      .req_delta_us (req_delta_us),
      .rsp_drive    (rsp_drive)
   );

`ifndef SYNTHESIS
   // go busy after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block did not go busy after accepting a beat");

   // a new result appears only at the end of work
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while idle");

   // return to idle when the result is posted
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("block still busy after posting result");
`endif

endmodule
